FILE: rtl/sorted_min_priority_queue_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for sorted_min_priority_queue
// Shared property templates that the checker uses.
// ----------------------------------------------------------------------------
`ifndef SORTED_MIN_PRIORITY_QUEUE_ASSERT_SVH
`define SORTED_MIN_PRIORITY_QUEUE_ASSERT_SVH

// same-cycle implication
`define SMPQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("smpq assertion failed");

// next-cycle implication
`define SMPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("smpq assertion failed");

`endif

FILE: rtl/smpq_pkg.sv
// ----------------------------------------------------------------------------
// smpq_pkg
// Shared constants and types for the sorted min priority queue.
// ----------------------------------------------------------------------------
package smpq_pkg;

    localparam int CAPACITY = 8;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam logic [1:0] OP_ENQ  = 2'd0;
    localparam logic [1:0] OP_DEQ  = 2'd1;
    localparam logic [1:0] OP_PEEK = 2'd2;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic enq;   // insert i_value in order
        logic deq;   // shift everything one place toward the head
    } t_cell_ctl;

endpackage

FILE: rtl/smpq_cell.sv
// ----------------------------------------------------------------------------
// smpq_cell
// One slot of the sorted chain: holds an entry and shifts or inserts.
// ----------------------------------------------------------------------------
module smpq_cell (
    input  logic                    i_clk,
    input  smpq_pkg::t_cell_ctl     i_ctl,
    input  logic                    i_occupied,
    input  logic signed [31:0]      i_value,
    input  logic signed [31:0]      i_left_entry,
    input  logic                    i_left_gt,
    input  logic signed [31:0]      i_right_entry,
    output logic signed [31:0]      o_entry,
    output logic                    o_gt
);
    import smpq_pkg::*;

    logic signed [31:0] r_entry;
    logic signed [31:0] n_entry;

    // held entry is strictly greater than the incoming value
    assign o_gt    = i_occupied && (r_entry > i_value);
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.enq) begin
            if (i_left_gt) begin
                n_entry = i_left_entry;     // make room: move right
            end else if (o_gt || !i_occupied) begin
                n_entry = i_value;          // insertion slot (or unused slot)
            end
        end else if (i_ctl.deq) begin
            n_entry = i_right_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

FILE: rtl/sorted_min_priority_queue.sv
// ----------------------------------------------------------------------------
// sorted_min_priority_queue
// Bounded ascending queue of signed 32-bit entries built as a chain of cells.
// ----------------------------------------------------------------------------
// Each accepted command's result is written into the output register.
// Throughput: one command per cycle while o_stall is low; every cell compares and shifts
//   in parallel, so insertion and removal both finish in the cycle of acceptance.
// Reset (i_rst_n low, synchronous): count goes to zero and the output register
//   empties; entry storage is not cleared, only slots below the count are read.
// ----------------------------------------------------------------------------
module sorted_min_priority_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // command channel
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_opcode,
    input  logic signed [31:0] i_value,
    // result channel
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_head_value,
    output logic               o_head_valid,
    output logic               o_dropped,
    output logic [6:0]         o_entry_count,
    output logic               o_is_full_flag,
    output logic               o_is_empty_flag
);
    import smpq_pkg::*;

    // ---------------- control state ----------------
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_out_valid;
    logic             n_out_valid;

    // ---------------- output payload ----------------
    logic signed [31:0] r_head_value;
    logic               r_head_valid;
    logic               r_dropped;
    logic [CNT_W-1:0]   r_out_count;

    logic       accept;
    logic       full;
    logic       empty;
    t_cell_ctl  ctl;

    // chain wiring
    logic signed [31:0] entry [CAPACITY];
    logic [CAPACITY-1:0] gt;
    logic [CAPACITY-1:0] occupied;

    // The result register parts the two channels: a new transaction is taken
    // whenever the register is empty or is being drained this cycle.
    assign o_stall = r_out_valid && i_stall;
    assign accept  = i_valid && !o_stall;

    assign full  = (r_count == CNT_W'(CAPACITY));
    assign empty = (r_count == '0);

    // Command decode; a full enqueue or empty dequeue leaves the chain alone.
    assign ctl.enq = accept && (i_opcode == OP_ENQ) && !full;
    assign ctl.deq = accept && (i_opcode == OP_DEQ) && !empty;

    always_comb begin
        n_count = r_count;
        if (ctl.enq) begin
            n_count = r_count + 1'b1;
        end else if (ctl.deq) begin
            n_count = r_count - 1'b1;
        end
    end

    // ---------------- cell chain ----------------
    // Slot 0 is the head. On insert, every slot whose left neighbor is greater than
    // the new value takes that neighbor's entry; the first greater slot (or the first
    // free slot) takes the new value. Equal entries stay ahead of the new one.
    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        logic signed [31:0] left_entry;
        logic               left_gt;
        logic signed [31:0] right_entry;

        assign occupied[k] = (CNT_W'(k) < r_count);

        if (k == 0) begin : g_head
            assign left_entry = i_value;
            assign left_gt    = 1'b0;
        end else begin : g_body
            assign left_entry = entry[k-1];
            assign left_gt    = gt[k-1];
        end

        if (k == CAPACITY - 1) begin : g_tail
            assign right_entry = entry[k];
        end else begin : g_mid
            assign right_entry = entry[k+1];
        end

        smpq_cell u_cell (
            .i_clk         (i_clk),
            .i_ctl         (ctl),
            .i_occupied    (occupied[k]),
            .i_value       (i_value),
            .i_left_entry  (left_entry),
            .i_left_gt     (left_gt),
            .i_right_entry (right_entry),
            .o_entry       (entry[k]),
            .o_gt          (gt[k])
        );
    end

    // ---------------- result register ----------------
    always_comb begin
        n_out_valid = r_out_valid && i_stall;
        if (accept) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // Peek and dequeue report the head as it stood before the command.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_head_valid <= ((i_opcode == OP_DEQ) || (i_opcode == OP_PEEK)) && !empty;
            r_head_value <= (((i_opcode == OP_DEQ) || (i_opcode == OP_PEEK)) && !empty)
                            ? entry[0] : 32'sd0;
            r_dropped    <= (i_opcode == OP_ENQ) && full;
            r_out_count  <= n_count;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_head_value    = r_head_value;
    assign o_head_valid    = r_head_valid;
    assign o_dropped       = r_dropped;
    assign o_entry_count   = 7'(r_out_count);
    assign o_is_full_flag  = (r_out_count == CNT_W'(CAPACITY));
    assign o_is_empty_flag = (r_out_count == '0);

endmodule

FILE: rtl/smpq_checker.sv
// ----------------------------------------------------------------------------
// smpq_checker
// Port-level checks for the sorted min priority queue, bound to the top level.
// ----------------------------------------------------------------------------
`include "sorted_min_priority_queue_assert.svh"

module smpq_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               o_valid,
    input  logic               i_stall,
    input  logic signed [31:0] o_head_value,
    input  logic               o_head_valid,
    input  logic               o_dropped,
    input  logic [6:0]         o_entry_count,
    input  logic               o_is_full_flag,
    input  logic               o_is_empty_flag
);
    import smpq_pkg::*;

    logic        drop_ok;
    logic        count_in_range;
    logic        flags_match;
    logic        head_zero;
    logic        held_off;
    logic [42:0] result_bits;

    assign drop_ok        = o_is_full_flag && !o_head_valid;
    assign count_in_range = (o_entry_count <= 7'(CAPACITY));
    assign flags_match    = (o_is_empty_flag == (o_entry_count == 7'd0)) &&
                            (o_is_full_flag == (o_entry_count == 7'(CAPACITY)));
    assign head_zero      = (o_head_value == 32'sd0);
    assign held_off       = o_valid && i_stall;
    assign result_bits    = {o_head_value, o_head_valid, o_dropped, o_entry_count,
                             o_is_full_flag, o_is_empty_flag};

    // a refused enqueue only happens on a full queue, which stays full
    `SMPQ_ASSERT_NOW(a_drop_full, i_clk, i_rst_n, o_valid && o_dropped, drop_ok)

    // count never exceeds capacity and flags agree with it
    `SMPQ_ASSERT_NOW(a_count_flags, i_clk, i_rst_n, o_valid, count_in_range && flags_match)

    // no real head means a zero head value
    `SMPQ_ASSERT_NOW(a_head_value_zero, i_clk, i_rst_n, o_valid && !o_head_valid, head_zero)

    // stalled result holds
    `SMPQ_ASSERT_NEXT(a_hold, i_clk, i_rst_n, held_off, o_valid && $stable(result_bits))

endmodule

bind sorted_min_priority_queue smpq_checker u_smpq_checker (.*);

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench for sorted_min_priority_queue
// Drives enqueue, dequeue, peek and unused-opcode transactions through the
// valid/stall command channel and checks every result against an in-bench
// model of the ascending queue, under several idle and backpressure mixes.
// ----------------------------------------------------------------------------
module testbench;

    import smpq_pkg::*;

    // the package has no name for the unused opcode
    localparam logic [1:0] OP_NOP = 2'd3;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int MAX_PRINTED    = 40;

    typedef struct packed {
        logic signed [31:0] head_value;
        logic               head_valid;
        logic               dropped;
        logic [6:0]         entry_count;
        logic               full_flag;
        logic               empty_flag;
    } t_queue_result;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic [1:0]         i_opcode;
    logic signed [31:0] i_value;
    logic               o_valid;
    logic               i_stall;
    logic signed [31:0] o_head_value;
    logic               o_head_valid;
    logic               o_dropped;
    logic [6:0]         o_entry_count;
    logic               o_is_full_flag;
    logic               o_is_empty_flag;

    // model of the queue contents, slot 0 is the head
    logic signed [31:0] model_entries [CAPACITY];
    int                 model_count;

    t_queue_result pending_results[$];
    t_queue_result got_result;
    t_queue_result want_result;

    int mismatch_count;
    int idle_pct;
    int stall_pct;
    int hold_left;
    int quiet_cycles;

    sorted_min_priority_queue i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_opcode        (i_opcode),
        .i_value         (i_value),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_head_value    (o_head_value),
        .o_head_valid    (o_head_valid),
        .o_dropped       (o_dropped),
        .o_entry_count   (o_entry_count),
        .o_is_full_flag  (o_is_full_flag),
        .o_is_empty_flag (o_is_empty_flag)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Applies one command to the model and returns the result it should give.
    function automatic t_queue_result apply_queue_command(input logic [1:0] op,
                                                          input logic signed [31:0] val);
        t_queue_result r;
        int            pos;
        r = '0;
        if (op == OP_ENQ) begin
            if (model_count >= CAPACITY) begin
                r.dropped = 1'b1;
            end else begin
                // equal values stay ahead of the newcomer
                pos = model_count;
                while (pos > 0 && model_entries[pos - 1] > val) begin
                    model_entries[pos] = model_entries[pos - 1];
                    pos--;
                end
                model_entries[pos] = val;
                model_count++;
            end
        end else if (op == OP_DEQ || op == OP_PEEK) begin
            if (model_count > 0) begin
                r.head_value = model_entries[0];
                r.head_valid = 1'b1;
                if (op == OP_DEQ) begin
                    for (pos = 1; pos < model_count; pos++)
                        model_entries[pos - 1] = model_entries[pos];
                    model_count--;
                end
            end
        end
        r.entry_count = 7'(model_count);
        r.full_flag   = (model_count == CAPACITY);
        r.empty_flag  = (model_count == 0);
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED)
            $display("mismatch at %0t: %s", $realtime, what);
    endtask

    task automatic compare_result(input t_queue_result got, input t_queue_result want);
        if (got.head_value !== want.head_value)
            report_mismatch($sformatf("head_value got %0d want %0d",
                                      got.head_value, want.head_value));
        if (got.head_valid !== want.head_valid)
            report_mismatch($sformatf("head_valid got %b want %b",
                                      got.head_valid, want.head_valid));
        if (got.dropped !== want.dropped)
            report_mismatch($sformatf("dropped got %b want %b", got.dropped, want.dropped));
        if (got.entry_count !== want.entry_count)
            report_mismatch($sformatf("entry_count got %0d want %0d",
                                      got.entry_count, want.entry_count));
        if (got.full_flag !== want.full_flag)
            report_mismatch($sformatf("is_full_flag got %b want %b",
                                      got.full_flag, want.full_flag));
        if (got.empty_flag !== want.empty_flag)
            report_mismatch($sformatf("is_empty_flag got %b want %b",
                                      got.empty_flag, want.empty_flag));
    endtask

    // Monitor: record accepted commands first, then check accepted results.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall)
                pending_results.push_back(apply_queue_command(i_opcode, i_value));
            if (o_valid && !i_stall) begin
                got_result = '{o_head_value, o_head_valid, o_dropped, o_entry_count,
                               o_is_full_flag, o_is_empty_flag};
                if (pending_results.size() == 0) begin
                    report_mismatch("result transaction with no command pending");
                end else begin
                    want_result = pending_results.pop_front();
                    compare_result(got_result, want_result);
                end
            end
        end
    end

    // Watchdog: cycles in which neither channel moves a transaction.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    // Result side: a long hold-off when requested, otherwise random stalls.
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_stall   <= 1'b1;
            hold_left <= hold_left - 1;
        end else begin
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Offers one command; returns at the edge where it is accepted.
    task automatic send_command(input logic [1:0] op, input logic signed [31:0] val);
        @(negedge i_clk);
        while ($urandom_range(99) < idle_pct) begin
            i_valid  <= 1'b0;
            i_opcode <= 2'($urandom);
            i_value  <= $urandom;
            @(negedge i_clk);
        end
        i_valid  <= 1'b1;
        i_opcode <= op;
        i_value  <= val;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic send_random_command(input int enq_pct);
        logic [1:0]         op;
        logic signed [31:0] val;
        int                 pick;
        pick = $urandom_range(99);
        if (pick >= 96)
            op = OP_NOP;
        else if (pick < enq_pct)
            op = OP_ENQ;
        else if (pick < enq_pct + (96 - enq_pct) * 2 / 3)
            op = OP_DEQ;
        else
            op = OP_PEEK;
        // extremes and a narrow band for duplicates, otherwise full range
        case ($urandom_range(7))
            0:       val = 32'sh7fffffff;
            1:       val = 32'sh80000000;
            2, 3:    val = int'($urandom_range(8)) - 4;
            default: val = $urandom;
        endcase
        send_command(op, val);
    endtask

    task automatic test_directed;
        idle_pct  = 0;
        stall_pct = 0;
        // empty queue: peek, dequeue and the unused opcode
        send_command(OP_PEEK, 32'sd77);
        send_command(OP_DEQ, -32'sd5);
        send_command(OP_NOP, 32'sh7fffffff);
        // fill with extremes, zero, near-zero and duplicates
        send_command(OP_ENQ, 32'sh7fffffff);
        send_command(OP_ENQ, 32'sh80000000);
        send_command(OP_ENQ, 32'sd0);
        send_command(OP_ENQ, -32'sd1);
        send_command(OP_ENQ, 32'sd1);
        send_command(OP_ENQ, 32'sd5);
        send_command(OP_ENQ, 32'sd5);
        send_command(OP_ENQ, 32'sh80000000);
        // full: enqueues are dropped
        send_command(OP_ENQ, 32'sd7);
        send_command(OP_ENQ, 32'sh80000000);
        send_command(OP_PEEK, 32'sd0);
        send_command(OP_NOP, 32'sd0);
        repeat (CAPACITY) send_command(OP_DEQ, 32'sd0);
        send_command(OP_DEQ, 32'sh55555555);
    endtask

    // Alternating fill-heavy and drain-heavy stretches keep the count
    // sweeping between empty and full.
    task automatic test_random_traffic(input int idle, input int stall, input int count);
        idle_pct  = idle;
        stall_pct = stall;
        for (int n = 0; n < count; n++)
            send_random_command(((n / 40) % 2 == 0) ? 70 : 30);
    endtask

    // Result side holds off while commands keep coming, so input stalls.
    task automatic test_backpressure;
        idle_pct  = 0;
        stall_pct = 0;
        hold_left = 300;
        repeat (40) send_random_command(60);
    endtask

    initial begin
        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_opcode       = OP_ENQ;
        i_value        = '0;
        i_stall        = 1'b0;
        idle_pct       = 0;
        stall_pct      = 0;
        hold_left      = 0;
        quiet_cycles   = 0;
        mismatch_count = 0;
        model_count    = 0;
        foreach (model_entries[k]) model_entries[k] = '0;

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed;
        test_random_traffic(0, 0, 280);
        test_random_traffic(71, 0, 280);
        test_random_traffic(0, 71, 280);
        test_random_traffic(7, 7, 280);
        test_backpressure;

        @(negedge i_clk);
        i_valid   <= 1'b0;
        stall_pct = 0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule

FILE: sorted_min_priority_queue.f
+incdir+rtl
rtl/smpq_pkg.sv
rtl/smpq_cell.sv
rtl/sorted_min_priority_queue.sv
rtl/smpq_checker.sv
tb/sv/testbench.sv
